// ===== hw/rtl/bitmap_store_with_bit_scan_core_assert.svh =====
// ----------------------------------------------------------------------------
// Bitmap store assertion macros
// Concurrent check macros used by the bitmap store controller.
// ----------------------------------------------------------------------------
`ifndef BITMAP_STORE_WITH_BIT_SCAN_CORE_ASSERT_SVH
`define BITMAP_STORE_WITH_BIT_SCAN_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BMSCAN_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("bmscan check failed");
`define BMSCAN_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("bmscan check failed");
`else
`define BMSCAN_ASSERT(label, clk, rst_n, prop)
`define BMSCAN_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/bmscan_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap store package
// Sizes, operation codes, controller states, interface structs and the
// bit position encoders of the bitmap store.
// ----------------------------------------------------------------------------
package bmscan_pkg;

	localparam int NUM_WORDS  = 64;
	localparam int WORD_BITS  = 64;
	localparam int BIT_W      = 6;
	localparam int IDX_W      = 12;
	localparam int WORD_IDX_W = IDX_W - BIT_W;
	localparam int ACTIVE_W   = 7;
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(64);
	localparam int MEM_DEPTH  = (NUM_WORDS < (1 << WORD_IDX_W)) ? NUM_WORDS
		: (1 << WORD_IDX_W);
	localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int NW_W       = $clog2(NUM_WORDS + 1);
	localparam int LIM_W_A    = (ACTIVE_W > NW_W) ? ACTIVE_W : NW_W;
	localparam int LIM_W      = (LIM_W_A > WORD_IDX_W + 1) ? LIM_W_A : WORD_IDX_W + 1;

	typedef enum logic [2:0] {
		OP_TEST     = 3'd0,
		OP_SET      = 3'd1,
		OP_CLEAR    = 3'd2,
		OP_SCAN_FWD = 3'd3,
		OP_SCAN_REV = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic run;
		logic out_now;
		logic hold_load;
		logic out_from_hold;
	} cmd_t;

	typedef struct packed {
		logic term;
	} sts_t;

	function automatic logic [BIT_W-1:0] lsb_pos(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0] one_hot;
		logic [BIT_W-1:0]     p;
		one_hot = w & (~w + WORD_BITS'(1));
		p = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			for (int k = 0; k < BIT_W; k++) begin
				p[k] = p[k] | (one_hot[i] & 1'(i >> k));
			end
		end
		return p;
	endfunction

	function automatic logic [BIT_W-1:0] msb_pos(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0] rev;
		for (int i = 0; i < WORD_BITS; i++) begin
			rev[i] = w[WORD_BITS-1-i];
		end
		return BIT_W'(BIT_W'(WORD_BITS - 1) - lsb_pos(rev));
	endfunction

endpackage

// ===== hw/rtl/bmscan_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bitmap store controller
// Sequences one item at a time through read, execute and result delivery,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
`include "bitmap_store_with_bit_scan_core_assert.svh"

module bmscan_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  bmscan_pkg::sts_t   sts,
	output bmscan_pkg::cmd_t   cmd
);

	bmscan_pkg::ctl_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bmscan_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bmscan_pkg::ST_RUN;
				end
			end
			bmscan_pkg::ST_RUN: begin
				if (sts.term) begin
					state_d = out_free ? bmscan_pkg::ST_IDLE : bmscan_pkg::ST_DONE;
				end
			end
			bmscan_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = bmscan_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bmscan_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			bmscan_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			bmscan_pkg::ST_RUN: begin
				cmd.run = 1'b1;
				cmd.out_now = sts.term && out_free;
				cmd.hold_load = sts.term && !out_free;
			end
			bmscan_pkg::ST_DONE: begin
				cmd.out_from_hold = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmscan_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_now || cmd.out_from_hold) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`BMSCAN_ASSERT(a_accept_runs, clk, arst_n, (state_q == bmscan_pkg::ST_IDLE) && in_valid |=> (state_q == bmscan_pkg::ST_RUN))
	`BMSCAN_NEVER(a_done_has_out, clk, arst_n, (state_q == bmscan_pkg::ST_DONE) && !out_valid_q)
	`BMSCAN_ASSERT(a_term_shows, clk, arst_n, (state_q == bmscan_pkg::ST_RUN) && sts.term |=> out_valid_q)

endmodule

// ===== hw/rtl/bmscan_dp.sv =====
// ----------------------------------------------------------------------------
// Bitmap store datapath
// Word memory with per-word valid bits, scan pointer, bit encoders,
// configuration register and result registers.
// ----------------------------------------------------------------------------
module bmscan_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [bmscan_pkg::ACTIVE_W-1:0]       cfg_wr_data,
	input  logic [2:0]                            op,
	input  logic [bmscan_pkg::IDX_W-1:0]          bit_index,
	output logic                                  hit,
	output logic [bmscan_pkg::IDX_W-1:0]          found_index,
	input  bmscan_pkg::cmd_t                      cmd,
	output bmscan_pkg::sts_t                      sts
);

	localparam int WB = bmscan_pkg::WORD_BITS;
	localparam int BW = bmscan_pkg::BIT_W;
	localparam int WW = bmscan_pkg::WORD_IDX_W;
	localparam int LW = bmscan_pkg::LIM_W;
	localparam int AW = bmscan_pkg::ADDR_W;
	localparam int DEPTH = bmscan_pkg::MEM_DEPTH;

	logic [WB-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	logic [bmscan_pkg::ACTIVE_W-1:0] active_q;
	logic [2:0]    op_q;
	logic [BW-1:0] bit_q;
	logic [WW-1:0] word_q;
	logic          first_q;
	logic [WB-1:0] rd_q;
	logic          rdv_q;
	logic          hold_hit_q;
	logic [bmscan_pkg::IDX_W-1:0] hold_found_q;
	logic          hit_q;
	logic [bmscan_pkg::IDX_W-1:0] found_q;

	logic [WB-1:0] word_val;
	logic [WB-1:0] fwd_mask, rev_mask, cur;
	logic [LW-1:0] lim, word_ext, word_p1, active_ext;
	logic          word_in_range;
	logic          term, step, res_hit;
	logic [WW-1:0] next_word, rd_word;
	logic [bmscan_pkg::IDX_W-1:0] res_found;
	logic          wr_en;
	logic [WB-1:0] wr_data;
	logic          rd_en;

	assign word_val = rdv_q ? rd_q : '0;
	assign fwd_mask = {WB{1'b1}} << bit_q;
	assign rev_mask = {WB{1'b1}} >> (BW'(WB - 1) - bit_q);
	assign active_ext = LW'(active_q);
	assign lim = (active_ext < LW'(bmscan_pkg::NUM_WORDS)) ? active_ext
		: LW'(bmscan_pkg::NUM_WORDS);
	assign word_ext = LW'(word_q);
	assign word_p1 = word_ext + LW'(1);
	assign word_in_range = word_ext < LW'(DEPTH);

	always_comb begin
		term = 1'b1;
		step = 1'b0;
		res_hit = 1'b0;
		res_found = '0;
		next_word = word_q;
		wr_en = 1'b0;
		wr_data = word_val;
		cur = word_val;
		case (op_q)
			bmscan_pkg::OP_TEST: begin
				res_hit = word_val[bit_q];
			end
			bmscan_pkg::OP_SET: begin
				wr_en = cmd.run && word_in_range;
				wr_data = word_val | (WB'(1) << bit_q);
			end
			bmscan_pkg::OP_CLEAR: begin
				wr_en = cmd.run && word_in_range;
				wr_data = word_val & ~(WB'(1) << bit_q);
			end
			bmscan_pkg::OP_SCAN_FWD: begin
				cur = first_q ? (word_val & fwd_mask) : word_val;
				if (first_q && word_ext >= lim) begin
					term = 1'b1;
				end else if (cur != '0) begin
					res_hit = 1'b1;
					res_found = {word_q, bmscan_pkg::lsb_pos(cur)};
				end else if (word_p1 >= lim) begin
					term = 1'b1;
				end else begin
					term = 1'b0;
					step = 1'b1;
					next_word = WW'(word_p1);
				end
			end
			bmscan_pkg::OP_SCAN_REV: begin
				cur = first_q ? (word_val & rev_mask) : word_val;
				if (cur != '0) begin
					res_hit = 1'b1;
					res_found = {word_q, bmscan_pkg::msb_pos(cur)};
				end else if (word_q == '0) begin
					term = 1'b1;
				end else begin
					term = 1'b0;
					step = 1'b1;
					next_word = word_q - WW'(1);
				end
			end
			default: begin
				term = 1'b1;
			end
		endcase
	end

	assign sts.term = term;
	assign rd_en = cmd.load || (cmd.run && step);
	assign rd_word = cmd.load ? bit_index[bmscan_pkg::IDX_W-1:BW] : next_word;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(word_q)] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[AW'(rd_word)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_q <= 1'b0;
			active_q <= bmscan_pkg::ACTIVE_RESET;
		end else begin
			if (wr_en) begin
				valid_q[AW'(word_q)] <= 1'b1;
			end
			if (rd_en) begin
				rdv_q <= valid_q[AW'(rd_word)] && (LW'(rd_word) < LW'(DEPTH));
			end
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			bit_q <= bit_index[BW-1:0];
			word_q <= bit_index[bmscan_pkg::IDX_W-1:BW];
			first_q <= 1'b1;
		end else if (cmd.run && step) begin
			word_q <= next_word;
			first_q <= 1'b0;
		end
		if (cmd.hold_load) begin
			hold_hit_q <= res_hit;
			hold_found_q <= res_found;
		end
		if (cmd.out_now) begin
			hit_q <= res_hit;
			found_q <= res_found;
		end else if (cmd.out_from_hold) begin
			hit_q <= hold_hit_q;
			found_q <= hold_found_q;
		end
	end

	assign hit = hit_q;
	assign found_index = found_q;

endmodule

// ===== hw/rtl/bitmap_store_with_bit_scan_core.sv =====
// ----------------------------------------------------------------------------
// Bitmap store with bit scan
// Bitmap of 64-bit words with test, set, clear and forward and reverse scan.
//
//   Channel  Handshake                Payload
//   cfg      cfg_wr_en                cfg_wr_data (active_words)
//   in       in_valid / in_stall      op, bit_index
//   out      out_valid / out_stall    hit, found_index
//
// Test, set, clear and unused codes are accepted with a word read, then
// executed. A forward scan visits one word per step up to the active words,
// and a start past the active words still spends a step on the range check.
// A reverse scan visits one word per step from the start down to the hit,
// or down to word zero when nothing is found.
// The single-ported word memory, read once per cycle, sets the scan rate.
// A result waiting on a stalled output is held until the output is free.
// Reset clears per-word valid bits, so the bitmap reads as zero at once.
// ----------------------------------------------------------------------------
module bitmap_store_with_bit_scan_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [bmscan_pkg::ACTIVE_W-1:0]       cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [2:0]                            op,
	input  logic [bmscan_pkg::IDX_W-1:0]          bit_index,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  hit,
	output logic [bmscan_pkg::IDX_W-1:0]          found_index
);

	bmscan_pkg::cmd_t cmd;
	bmscan_pkg::sts_t sts;

	bmscan_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bmscan_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.op          (op),
		.bit_index   (bit_index),
		.hit         (hit),
		.found_index (found_index),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

// ===== tb/tb_bitmap_store_with_bit_scan_core.sv =====
// ----------------------------------------------------------------------------
// Bitmap store with bit scan testbench
// Drives test, set, clear and both scan directions into the bitmap store
// under several active word counts, with random idling on both channels.
// A scoreboard keeps its own copy of the bitmap, predicts every result and
// checks the results in order as they leave the block.
// ----------------------------------------------------------------------------
module tb_bitmap_store_with_bit_scan_core;
	import bmscan_pkg::*;

	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int NUM_PHASES = 5;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 80;
	localparam logic [2:0] OP_CODE_MAX = 3'd7;
	localparam logic [ACTIVE_W-1:0] ACTIVE_MAX = '1;
	localparam logic [IDX_W-1:0] INDEX_MAX = '1;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] found_index;
	} bit_result_t;

	class bitmap_scoreboard;
		logic [WORD_BITS-1:0] words [NUM_WORDS];
		logic [ACTIVE_W-1:0]  active_words;
		bit_result_t          expected_q [$];
		int                   n_errors;
		int                   n_checked;
		int                   n_scan_hits;
		int                   n_scan_misses;
		int                   n_ops [8];

		function new();
			foreach (words[i]) words[i] = '0;
			foreach (n_ops[i]) n_ops[i] = 0;
			active_words = ACTIVE_RESET;
			n_errors = 0;
			n_checked = 0;
			n_scan_hits = 0;
			n_scan_misses = 0;
		endfunction

		function void set_active_words(logic [ACTIVE_W-1:0] value);
			active_words = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function int lowest_set(logic [WORD_BITS-1:0] w);
			for (int i = 0; i < WORD_BITS; i++) begin
				if (w[i]) return i;
			end
			return 0;
		endfunction

		function int highest_set(logic [WORD_BITS-1:0] w);
			for (int i = WORD_BITS - 1; i >= 0; i--) begin
				if (w[i]) return i;
			end
			return 0;
		endfunction

		function void note_item(logic [2:0] code, logic [IDX_W-1:0] idx);
			int                   word_num;
			int                   bit_num;
			int                   limit;
			logic [WORD_BITS-1:0] cur;
			bit_result_t          res;
			word_num = int'(idx >> BIT_W);
			bit_num = int'(idx[BIT_W-1:0]);
			res = '0;
			n_ops[int'(code)]++;
			case (code)
				OP_TEST: begin
					if (word_num < NUM_WORDS) res.hit = words[word_num][bit_num];
				end
				OP_SET: begin
					if (word_num < NUM_WORDS) words[word_num][bit_num] = 1'b1;
				end
				OP_CLEAR: begin
					if (word_num < NUM_WORDS) words[word_num][bit_num] = 1'b0;
				end
				OP_SCAN_FWD: begin
					limit = (int'(active_words) < NUM_WORDS) ? int'(active_words) : NUM_WORDS;
					for (int w = word_num; w < limit; w++) begin
						cur = words[w];
						if (w == word_num) cur = cur & ({WORD_BITS{1'b1}} << bit_num);
						if (cur != '0) begin
							res.hit = 1'b1;
							res.found_index = IDX_W'(w * WORD_BITS + lowest_set(cur));
							break;
						end
					end
				end
				OP_SCAN_REV: begin
					for (int w = word_num; w >= 0; w--) begin
						cur = (w < NUM_WORDS) ? words[w] : '0;
						if (w == word_num) begin
							cur = cur & ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - bit_num));
						end
						if (cur != '0) begin
							res.hit = 1'b1;
							res.found_index = IDX_W'(w * WORD_BITS + highest_set(cur));
							break;
						end
					end
				end
				default: ;
			endcase
			if (code == OP_SCAN_FWD || code == OP_SCAN_REV) begin
				if (res.hit) n_scan_hits++;
				else n_scan_misses++;
			end
			expected_q.push_back(res);
		endfunction

		function void check_result(logic hit_v, logic [IDX_W-1:0] index_v);
			bit_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, hit %0b found_index %0d", $time, hit_v, index_v);
				n_errors++;
				return;
			end
			want = expected_q.pop_front();
			n_checked++;
			if (hit_v !== want.hit) begin
				$display("%0t: hit expected %0b actual %0b", $time, want.hit, hit_v);
				n_errors++;
			end
			if (index_v !== want.found_index) begin
				$display("%0t: found_index expected %0d actual %0d", $time, want.found_index,
					index_v);
				n_errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [ACTIVE_W-1:0] cfg_wr_data = ACTIVE_RESET;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [2:0]          op = OP_TEST;
	logic [IDX_W-1:0]    bit_index = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                hit;
	logic [IDX_W-1:0]    found_index;

	bitmap_scoreboard    sb = new();
	int                  cycle_count = 0;
	logic                hold_off_req = 1'b0;
	logic [IDX_W-1:0]    last_set_index = '0;

	bitmap_store_with_bit_scan_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.bit_index  (bit_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.found_index(found_index)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(hit, found_index);
	end

	initial begin : out_stall_gen
		int r;
		int len;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (r < 50) begin
				out_stall <= 1'b0;
				len = $urandom_range(1, 8);
				repeat (len) @(posedge clk);
			end else if (r < 85) begin
				out_stall <= 1'b1;
				len = $urandom_range(1, 3);
				repeat (len) @(posedge clk);
			end else if (r < 95) begin
				out_stall <= 1'b0;
				len = $urandom_range(20, 60);
				repeat (len) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				len = $urandom_range(10, 40);
				repeat (len) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input logic [2:0] code, input logic [IDX_W-1:0] idx);
		in_valid <= 1'b1;
		op <= code;
		bit_index <= idx;
		do @(posedge clk); while (in_stall);
		sb.note_item(code, idx);
	endtask

	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic send_directed(input logic [2:0] code, input logic [IDX_W-1:0] idx);
		send_item(code, idx);
		idle_gap(pick_gap());
	endtask

	task automatic wait_drained();
		if (in_valid) in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_active_words(input logic [ACTIVE_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_active_words(value);
	endtask

	task automatic send_random_item();
		int               r;
		int               span;
		logic [2:0]       code;
		logic [IDX_W-1:0] idx;
		r = $urandom_range(0, 99);
		if (r < 30) code = OP_SET;
		else if (r < 42) code = OP_CLEAR;
		else if (r < 57) code = OP_TEST;
		else if (r < 75) code = OP_SCAN_FWD;
		else if (r < 93) code = OP_SCAN_REV;
		else code = 3'($urandom_range(int'(OP_SCAN_REV) + 1, int'(OP_CODE_MAX)));
		// Most indices land inside the words a forward scan may visit or
		// next to a bit that was set recently, so scans meet real data.
		span = (sb.active_words == 0) ? 1
			: ((int'(sb.active_words) > NUM_WORDS) ? NUM_WORDS : int'(sb.active_words));
		r = $urandom_range(0, 99);
		if (r < 35) idx = IDX_W'($urandom);
		else if (r < 70) idx = IDX_W'($urandom_range(0, span * WORD_BITS - 1));
		else idx = last_set_index + IDX_W'($urandom_range(0, 8)) - IDX_W'(4);
		if (code == OP_SET) last_set_index = idx;
		send_item(code, idx);
	endtask

	initial begin : stimulus
		logic [ACTIVE_W-1:0] phase_setting [NUM_PHASES];
		int                  burst_left;
		int                  gap;
		phase_setting[0] = ACTIVE_W'(1);
		phase_setting[1] = '0;
		phase_setting[2] = ACTIVE_MAX;
		phase_setting[3] = ACTIVE_W'($urandom_range(2, NUM_WORDS - 1));
		phase_setting[4] = ACTIVE_W'(NUM_WORDS);
		burst_left = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_active_words(ACTIVE_RESET);

		// Empty bitmap: nothing to find in either direction.
		send_directed(OP_TEST, '0);
		send_directed(OP_SCAN_FWD, '0);
		send_directed(OP_SCAN_REV, INDEX_MAX);
		// Bits at both ends of the bitmap and across a word boundary.
		send_directed(OP_SET, '0);
		send_directed(OP_SET, IDX_W'(63));
		send_directed(OP_SET, IDX_W'(64));
		send_directed(OP_SET, INDEX_MAX);
		send_directed(OP_TEST, '0);
		send_directed(OP_TEST, IDX_W'(1));
		send_directed(OP_TEST, INDEX_MAX);
		send_directed(OP_SCAN_FWD, IDX_W'(1));
		send_directed(OP_SCAN_FWD, IDX_W'(65));
		send_directed(OP_SCAN_REV, IDX_W'(62));
		send_directed(OP_SCAN_REV, INDEX_MAX - IDX_W'(1));
		send_directed(OP_SCAN_REV, '0);
		// Unused operation codes leave the bitmap alone.
		send_directed(3'(int'(OP_SCAN_REV) + 1), INDEX_MAX);
		send_directed(3'(int'(OP_SCAN_REV) + 2), '0);
		send_directed(OP_CODE_MAX, INDEX_MAX);
		send_directed(OP_CLEAR, INDEX_MAX);
		send_directed(OP_CLEAR, '0);
		send_directed(OP_SCAN_FWD, INDEX_MAX);
		send_directed(OP_SCAN_REV, IDX_W'(63));
		wait_drained();

		// One active word: a start past it finds nothing, reverse ignores it.
		write_active_words(ACTIVE_W'(1));
		send_directed(OP_SCAN_FWD, '0);
		send_directed(OP_SCAN_FWD, IDX_W'(64));
		send_directed(OP_SCAN_REV, INDEX_MAX);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_active_words(phase_setting[p]);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// With all active words allowed, hold the output off for a long
				// stretch while items keep coming so the block backs up.
				if (p == 2 && i == 20) hold_off_req = 1'b1;
				send_random_item();
				if (burst_left > 0) burst_left--;
				else if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 30);
				gap = (hold_off_req || burst_left > 0) ? 0 : pick_gap();
				idle_gap(gap);
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d tests, %0d sets, %0d clears, %0d forward and %0d reverse scans",
			sb.n_ops[OP_TEST], sb.n_ops[OP_SET], sb.n_ops[OP_CLEAR], sb.n_ops[OP_SCAN_FWD],
			sb.n_ops[OP_SCAN_REV]);
		$display("plus unused codes over %0d active word settings; %0d scans hit, %0d missed",
			NUM_PHASES + 2, sb.n_scan_hits, sb.n_scan_misses);
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
